>>> src/tlf_pkg.sv
// constants shared by the line framer
package tlf_pkg;

    localparam int MAX_LINE = 64;
    localparam int CNT_W    = $clog2(MAX_LINE + 1);
    localparam int ADDR_W   = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;

endpackage

>>> src/text_line_framer.sv
// newline-delimited line framer: collects received bytes, emits finished lines
//
// Input channel: i_in_valid / o_in_stall carry one received byte per beat on
// i_rx_byte. Output channel: o_out_valid / i_out_stall carry one line byte per
// beat on o_line_byte, with o_line_end set on the last byte of the line.
// A byte other than newline is written into the line memory when accepted, so
// input runs at one beat per cycle while a line is being collected.
// When a newline closes a non-empty line (a trailing carriage return removed),
// the block stalls input while it reads the line memory, one address per
// cycle while the receiver does not stall the output; input resumes once the
// read of the last line byte has been issued. o_out_valid for the first line
// byte rises after the state register enters reading, the read is issued
// into the registered memory output and the output register is loaded; the
// rest follow one per cycle while the receiver does not stall the output.
// A line longer than MAX_LINE bytes is dropped, and bytes up to and including
// the next newline are discarded. Empty lines give no output.
// A receiver stall holds the output register; the memory read data register
// absorbs one more byte before reads pause.
// Reset (synchronous, active low) empties the line and leaves the discard
// mode; the line memory itself is not cleared.
module text_line_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_line_byte,
    output logic       o_line_end
);
    import tlf_pkg::*;

    typedef enum logic {
        S_COLLECT,
        S_READ
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_fill;
    logic               r_resync;
    logic               r_last_cr;
    logic [CNT_W-1:0]   r_len;
    logic [CNT_W-1:0]   r_rd_idx;

    logic [7:0]         r_mem [MAX_LINE];
    logic [7:0]         r_q_data;
    logic               r_q_valid;
    logic               r_q_end;
    logic [7:0]         r_out_byte;
    logic               r_out_end;
    logic               r_out_valid;

    logic               in_acc;
    logic               is_nl;
    logic               wr_en;
    logic               rd_en;
    logic               rd_last;
    logic               q_take;
    logic [CNT_W-1:0]   n_len;

    assign o_in_stall  = (r_state == S_READ);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign is_nl       = (i_rx_byte == CH_NEWLINE);
    assign n_len       = r_fill - {{(CNT_W-1){1'b0}}, r_last_cr};
    assign wr_en       = in_acc && !r_resync && !is_nl
                         && (r_fill != CNT_W'(MAX_LINE));
    assign q_take      = r_q_valid && (!r_out_valid || !i_out_stall);
    assign rd_en       = (r_state == S_READ) && (r_rd_idx < r_len)
                         && (!r_q_valid || q_take);
    assign rd_last     = (r_rd_idx == (r_len - CNT_W'(1)));

    // line memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_fill[ADDR_W-1:0]] <= i_rx_byte;
        end
        if (rd_en) begin
            r_q_data <= r_mem[r_rd_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_COLLECT;
            r_fill      <= '0;
            r_resync    <= 1'b0;
            r_last_cr   <= 1'b0;
            r_len       <= '0;
            r_rd_idx    <= '0;
            r_q_valid   <= 1'b0;
            r_q_end     <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_byte  <= '0;
            r_out_end   <= 1'b0;
        end else begin
            if (in_acc) begin
                priority if (r_resync) begin
                    if (is_nl) begin
                        r_resync  <= 1'b0;
                        r_fill    <= '0;
                        r_last_cr <= 1'b0;
                    end
                end else if (is_nl) begin
                    r_fill    <= '0;
                    r_last_cr <= 1'b0;
                    if (n_len != '0) begin
                        r_state  <= S_READ;
                        r_len    <= n_len;
                        r_rd_idx <= '0;
                    end
                end else if (r_fill == CNT_W'(MAX_LINE)) begin
                    // overlong line: drop it and wait for the next newline
                    r_fill    <= '0;
                    r_last_cr <= 1'b0;
                    r_resync  <= 1'b1;
                end else begin
                    r_fill    <= r_fill + CNT_W'(1);
                    r_last_cr <= (i_rx_byte == CH_CR);
                end
            end

            if (rd_en) begin
                r_rd_idx <= r_rd_idx + CNT_W'(1);
                r_q_end  <= rd_last;
                // data is captured at issue, so collecting may resume at once
                if (rd_last) begin
                    r_state <= S_COLLECT;
                end
            end

            if (rd_en) begin
                r_q_valid <= 1'b1;
            end else if (q_take) begin
                r_q_valid <= 1'b0;
            end

            if (q_take) begin
                r_out_valid <= 1'b1;
                r_out_byte  <= r_q_data;
                r_out_end   <= r_q_end;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_line_byte = r_out_byte;
    assign o_line_end  = r_out_end;

    a_fill_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(MAX_LINE))
        else $error("line fill count beyond line memory");

    a_rd_in_line : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (r_rd_idx < r_len) && (r_len != '0))
        else $error("read issued past end of line");

    a_q_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_valid && !q_take) |=> r_q_valid && $stable(r_q_data))
        else $error("pending read data overwritten");

    a_resync_quiet : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && r_resync) |=> (r_state == S_COLLECT) && (r_fill == '0))
        else $error("discarded byte changed line state");

endmodule
